// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check that a property holds at every rising clock edge outside reset.
`define MAF_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Check that a condition never holds at a rising clock edge outside reset.
`define MAF_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define MAF_ASSERT(lbl, clk, rstn, prop, msg)
`define MAF_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

// ===== rtl/maf_pkg.sv =====
package maf_pkg;

	// Sequencer states of the filter
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SUM,
		ST_DIV
	} state_t;

	// Status of the serial divider
	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

// ===== rtl/maf_if.sv =====
// Sample channel: one signed sample per item.
interface maf_sample_if #(
	parameter int W = 16
) ();
	logic                valid;
	logic                ready;
	logic signed [W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

// Mean channel: one signed mean per item.
interface maf_mean_if #(
	parameter int W = 16
) ();
	logic                valid;
	logic                ready;
	logic signed [W-1:0] mean;

	modport source (output valid, output mean, input ready);
	modport sink (input valid, input mean, output ready);
endinterface

// ===== rtl/maf_ring.sv =====
module maf_ring #(
	parameter int DEPTH       = 16,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  logic signed [SAMPLE_BITS-1:0] wdata,
	output logic signed [SAMPLE_BITS-1:0] old_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic signed [SAMPLE_BITS-1:0] mem [DEPTH];
	logic        [PTR_W-1:0]       wp_q;
	logic signed [SAMPLE_BITS-1:0] old_q;

	// Advance the write pointer, wrap after the last entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
		end else if (push) begin
			if (wp_q == PTR_W'(DEPTH - 1)) begin
				wp_q <= '0;
			end else begin
				wp_q <= wp_q + 1'b1;
			end
		end
	end

	// Read the entry about to be overwritten, then write the new sample
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wp_q] <= wdata;
			old_q     <= mem[wp_q];
		end
	end

	assign old_data = old_q;

endmodule

// ===== rtl/maf_divider.sv =====
module maf_divider #(
	parameter int SUM_W       = 20,
	parameter int CNT_W       = 5,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [SUM_W-1:0]       dividend,
	input  logic        [CNT_W-1:0]       divisor,
	output maf_pkg::div_status_t          status,
	output logic signed [SAMPLE_BITS-1:0] quotient
);

	localparam int STEP_W = $clog2(SUM_W + 1);

	logic [STEP_W-1:0] step_q;
	logic              done_q;
	logic [SUM_W-1:0]  mag_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  div_q;
	logic              neg_q;
	logic [SUM_W-1:0]  dividend_mag;
	logic [CNT_W:0]    trial;
	logic [CNT_W:0]    diff;
	logic              fits;
	logic [SUM_W-1:0]  q_full;

	assign dividend_mag = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);

	// One restoring step: shift in the next dividend bit, subtract if it fits
	assign trial = {rem_q, mag_q[SUM_W-1]};
	assign diff  = trial - {1'b0, div_q};
	assign fits  = (trial >= {1'b0, div_q});

	// Count the steps, flag the quotient when the last one is done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			step_q <= STEP_W'(SUM_W);
			done_q <= 1'b0;
		end else if (step_q != '0) begin
			step_q <= step_q - 1'b1;
			if (step_q == STEP_W'(1)) begin
				done_q <= 1'b1;
			end
		end
	end

	// Load magnitudes on start, then shift one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= dividend_mag;
			rem_q <= '0;
			div_q <= divisor;
			neg_q <= dividend[SUM_W-1];
		end else if (step_q != '0) begin
			mag_q <= {mag_q[SUM_W-2:0], fits};
			if (fits) begin
				rem_q <= diff[CNT_W-1:0];
			end else begin
				rem_q <= trial[CNT_W-1:0];
			end
		end
	end

	// Restore the sign of the dividend; the divisor is always positive
	assign q_full   = neg_q ? (~mag_q + 1'b1) : mag_q;
	assign quotient = q_full[SAMPLE_BITS-1:0];

	assign status.busy = (step_q != '0);
	assign status.done = done_q;

	`include "assert_macros.svh"

	`MAF_ASSERT(a_start_idle, clk, arst_n, start |-> (step_q == '0), "divider restarted while busy")
	`MAF_ASSERT_NEVER(a_busy_done, clk, arst_n, (step_q != '0) && done_q, "divider done while busy")
	`MAF_ASSERT(a_last_step, clk, arst_n, (!start && step_q == STEP_W'(1)) |=> done_q, "divider missed done")

endmodule

// ===== rtl/moving_average_filter_unit.sv =====
// Moving average filter over the last DEPTH samples.
// in_ch carries one signed sample per item; out_ch returns one signed mean per
// item, the mean of the samples held so far truncated toward zero. Until DEPTH
// samples have arrived the sum is divided by the number received, after that
// by DEPTH.
// A sample's mean is valid once the sum update in ST_SUM, the serial divide in
// ST_DIV and the load of the output register are through, where SUM_W =
// SAMPLE_BITS + clog2(DEPTH). in_ch.ready is high only while the sequencer is
// idle, so a new sample is taken only after the mean of the last one is done.
// The serial divider makes one quotient bit per cycle over SUM_W bits.
// The mean waits in an output register, so a stalled receiver does not block
// the next sample; only if a mean is still unread when the following one is
// done does the sequencer hold until out_ch.ready.
// Reset clears the write pointer, fill count, running sum and output valid.
// The sample ring needs no clearing: an entry is read back only after it was
// written.
module moving_average_filter_unit #(
	parameter int DEPTH       = 16,
	parameter int SAMPLE_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	maf_sample_if.sink     in_ch,
	maf_mean_if.source     out_ch
);

	localparam int SUM_W = SAMPLE_BITS + $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	maf_pkg::state_t               state_q;
	maf_pkg::state_t               state_d;
	maf_pkg::div_status_t          div_st;
	logic                          accept;
	logic                          div_start;
	logic                          ld_out;
	logic                          out_free;
	logic                          full;
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic signed [SAMPLE_BITS-1:0] old_sample;
	logic signed [SUM_W-1:0]       sum_q;
	logic signed [SUM_W-1:0]       sum_next;
	logic signed [SUM_W-1:0]       drop_term;
	logic        [CNT_W-1:0]       fill_q;
	logic        [CNT_W-1:0]       fill_next;
	logic signed [SAMPLE_BITS-1:0] quotient;
	logic signed [SAMPLE_BITS-1:0] mean_q;
	logic                          out_valid_q;

	assign accept   = in_ch.valid && in_ch.ready;
	assign out_free = !out_valid_q || out_ch.ready;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			maf_pkg::ST_IDLE: begin
				if (in_ch.valid) begin
					state_d = maf_pkg::ST_SUM;
				end
			end
			maf_pkg::ST_SUM: begin
				state_d = maf_pkg::ST_DIV;
			end
			maf_pkg::ST_DIV: begin
				if (div_st.done && out_free) begin
					state_d = maf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = maf_pkg::ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs
	always_comb begin
		in_ch.ready = 1'b0;
		div_start   = 1'b0;
		ld_out      = 1'b0;
		unique case (state_q)
			maf_pkg::ST_IDLE: begin
				in_ch.ready = 1'b1;
			end
			maf_pkg::ST_SUM: begin
				div_start = 1'b1;
			end
			maf_pkg::ST_DIV: begin
				ld_out = div_st.done && out_free;
			end
			default: begin
				in_ch.ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= maf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Hold the accepted sample
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= in_ch.sample;
		end
	end

	maf_ring #(
		.DEPTH       (DEPTH),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_ring (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.wdata    (in_ch.sample),
		.old_data (old_sample)
	);

	// Add the new sample, drop the overwritten one once the ring is full
	assign full      = (fill_q == CNT_W'(DEPTH));
	assign drop_term = full ? SUM_W'(old_sample) : '0;
	assign sum_next  = sum_q + SUM_W'(sample_q) - drop_term;
	assign fill_next = full ? fill_q : fill_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			fill_q <= '0;
		end else if (div_start) begin
			sum_q  <= sum_next;
			fill_q <= fill_next;
		end
	end

	maf_divider #(
		.SUM_W       (SUM_W),
		.CNT_W       (CNT_W),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_next),
		.divisor  (fill_next),
		.status   (div_st),
		.quotient (quotient)
	);

	// Output register: load a finished mean, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out) begin
			mean_q <= quotient;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.mean  = mean_q;

	`include "assert_macros.svh"

	`MAF_ASSERT(a_accept_to_sum, clk, arst_n, accept |=> (state_q == maf_pkg::ST_SUM), "accepted item not summed")
	`MAF_ASSERT_NEVER(a_fill_bound, clk, arst_n, fill_q > CNT_W'(DEPTH), "fill count beyond depth")
	`MAF_ASSERT(a_busy_in_div, clk, arst_n, div_st.busy |-> (state_q == maf_pkg::ST_DIV), "divider busy outside divide")
	`MAF_ASSERT(a_load_free, clk, arst_n, ld_out |-> (!out_valid_q || out_ch.ready), "unread mean overwritten")

endmodule
